@@ hdl/clut_texel_decoder_macros.svh @@
// Assertion macros used by the decoder top level.
`ifndef CLUT_TEXEL_DECODER_MACROS_SVH
`define CLUT_TEXEL_DECODER_MACROS_SVH

`ifndef SYNTHESIS

// expr must hold at every clock edge outside reset
`define CTD_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// cons must hold in the cycle after ante
`define CTD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define CTD_ASSERT_ALWAYS(lbl, clk, rst, expr)
`define CTD_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

@@ hdl/ctd_pkg.sv @@
package ctd_pkg;

   // palette store geometry
   localparam int PALETTE_DEPTH = 256;
   localparam int REMAP_BLOCK   = 32;
   localparam int ADDR_W        = $clog2(PALETTE_DEPTH);
   localparam int LOCAL_W       = $clog2(REMAP_BLOCK);

   // field widths
   localparam int POS_W   = 8;
   localparam int WORD_W  = 32;
   localparam int FMT_W   = 3;
   localparam int COUNT_W = 9;

   // indexes at or above this are past the store
   localparam logic [COUNT_W-1:0] IDX_LIMIT = COUNT_W'(PALETTE_DEPTH);

   // format codes
   localparam logic [FMT_W-1:0] FMT_RGB16 = 3'd0;
   localparam logic [FMT_W-1:0] FMT_RGB24 = 3'd1;
   localparam logic [FMT_W-1:0] FMT_RGB32 = 3'd2;
   localparam logic [FMT_W-1:0] FMT_IDX4  = 3'd3;
   localparam logic [FMT_W-1:0] FMT_IDX8  = 3'd4;

   // register indexes (word address)
   localparam logic [2:0] REG_IMAGE_FORMAT     = 3'd0;
   localparam logic [2:0] REG_PALETTE_FORMAT   = 3'd1;
   localparam logic [2:0] REG_PALETTE_CSM2     = 3'd2;
   localparam logic [2:0] REG_PALETTE_COMPOUND = 3'd3;
   localparam logic [2:0] REG_PALETTE_COUNT    = 3'd4;

   typedef struct packed {
      logic [FMT_W-1:0]   image_format;
      logic [FMT_W-1:0]   palette_format;
      logic               palette_csm2;
      logic               palette_compound;
      logic [COUNT_W-1:0] palette_count;
   } cfg_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [WORD_W-1:0] data;
   } ram_wr_type;

   // what the first stage carries for a pixel word
   typedef struct packed {
      logic              use_mem;
      logic [WORD_W-1:0] direct;
   } pix_info_type;

   // raw color word to RGBA8 (red in the low byte)
   function automatic logic [WORD_W-1:0] convert_word(logic [FMT_W-1:0] fmt,
                                                      logic [WORD_W-1:0] w);
      logic [WORD_W-1:0] r;
      unique case (fmt)
         FMT_RGB16: r = {(w[15] ? 8'hFF : 8'h00), w[14:10], 3'b000,
                         w[9:5], 3'b000, w[4:0], 3'b000};
         FMT_RGB24: r = {8'hFF, w[23:0]};
         FMT_RGB32: r = w;
         default:   r = '0;
      endcase
      return r;
   endfunction

endpackage

@@ hdl/ctd_req_if.sv @@
interface ctd_req_if;
   logic                       valid;
   logic                       ready;
   logic                       func;
   logic [ctd_pkg::POS_W-1:0]  entry_position;
   logic [ctd_pkg::WORD_W-1:0] entry_word;
   logic [ctd_pkg::WORD_W-1:0] pixel_word;
   logic                       pixel_odd;

   modport source(output valid, func, entry_position, entry_word, pixel_word,
                  pixel_odd, input ready);
   modport sink(input valid, func, entry_position, entry_word, pixel_word,
                pixel_odd, output ready);
endinterface

@@ hdl/ctd_rsp_if.sv @@
interface ctd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] alpha;

   modport source(output valid, red, green, blue, alpha, input ready);
   modport sink(input valid, red, green, blue, alpha, output ready);
endinterface

@@ hdl/ctd_csr.sv @@
module ctd_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [4:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready,
   output ctd_pkg::cfg_type    cfg
);

   ctd_pkg::cfg_type cfg_ff, cfg_in;
   logic             wr_en;
   logic [2:0]       reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[4:2];
   assign cfg     = cfg_ff;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            ctd_pkg::REG_IMAGE_FORMAT:     cfg_in.image_format     = pwdata[2:0];
            ctd_pkg::REG_PALETTE_FORMAT:   cfg_in.palette_format   = pwdata[2:0];
            ctd_pkg::REG_PALETTE_CSM2:     cfg_in.palette_csm2     = pwdata[0];
            ctd_pkg::REG_PALETTE_COMPOUND: cfg_in.palette_compound = pwdata[0];
            ctd_pkg::REG_PALETTE_COUNT:    cfg_in.palette_count    = pwdata[8:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back
   always_comb begin
      unique case (reg_idx)
         ctd_pkg::REG_IMAGE_FORMAT:     prdata = {29'd0, cfg_ff.image_format};
         ctd_pkg::REG_PALETTE_FORMAT:   prdata = {29'd0, cfg_ff.palette_format};
         ctd_pkg::REG_PALETTE_CSM2:     prdata = {31'd0, cfg_ff.palette_csm2};
         ctd_pkg::REG_PALETTE_COMPOUND: prdata = {31'd0, cfg_ff.palette_compound};
         ctd_pkg::REG_PALETTE_COUNT:    prdata = {23'd0, cfg_ff.palette_count};
         default:                       prdata = '0;
      endcase
   end

endmodule

@@ hdl/ctd_ram.sv @@
module ctd_ram #(
   parameter  int DEPTH = 256,
   parameter  int WIDTH = 32,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   assign rdata = rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // registered read, holds when not enabled
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

endmodule

@@ hdl/ctd_decode.sv @@
module ctd_decode (
   input  ctd_pkg::cfg_type                cfg,
   input  logic [ctd_pkg::POS_W-1:0]       entry_position,
   input  logic [ctd_pkg::WORD_W-1:0]      entry_word,
   input  logic [ctd_pkg::WORD_W-1:0]      pixel_word,
   input  logic                            pixel_odd,
   output ctd_pkg::ram_wr_type             wr,
   output logic [ctd_pkg::ADDR_W-1:0]      raddr,
   output ctd_pkg::pix_info_type           info
);

   logic [ctd_pkg::POS_W-1:0] pos;
   logic [1:0]                quarter;
   logic [7:0]                idx;
   logic                      idx_ok;

   // compound swap (csm2 off) of the second and third quarters of each block
   always_comb begin
      pos     = entry_position;
      quarter = entry_position[ctd_pkg::LOCAL_W-1:ctd_pkg::LOCAL_W-2];
      if (cfg.palette_compound && !cfg.palette_csm2) begin
         if (quarter == 2'b01 || quarter == 2'b10) begin
            pos[ctd_pkg::LOCAL_W-1:ctd_pkg::LOCAL_W-2] = ~quarter;
         end
      end
   end

   // palette entry write; positions past the store are dropped
   assign wr.we   = ({1'b0, pos} < ctd_pkg::IDX_LIMIT);
   assign wr.addr = pos[ctd_pkg::ADDR_W-1:0];
   assign wr.data = ctd_pkg::convert_word(cfg.palette_format, entry_word);

   // palette index of an indexed pixel
   always_comb begin
      if (cfg.image_format == ctd_pkg::FMT_IDX4) begin
         idx = {4'd0, (pixel_odd ? pixel_word[7:4] : pixel_word[3:0])};
      end else begin
         idx = pixel_word[7:0];
      end
   end

   assign idx_ok = (cfg.palette_count != '0)
                && ({1'b0, idx} < cfg.palette_count)
                && ({1'b0, idx} < ctd_pkg::IDX_LIMIT);
   assign raddr  = idx[ctd_pkg::ADDR_W-1:0];

   // direct conversion or palette lookup, else zero
   always_comb begin
      info.use_mem = 1'b0;
      info.direct  = '0;
      if (cfg.image_format == ctd_pkg::FMT_RGB16
          || cfg.image_format == ctd_pkg::FMT_RGB24
          || cfg.image_format == ctd_pkg::FMT_RGB32) begin
         info.direct = ctd_pkg::convert_word(cfg.image_format, pixel_word);
      end else if (cfg.image_format == ctd_pkg::FMT_IDX4
                   || cfg.image_format == ctd_pkg::FMT_IDX8) begin
         info.use_mem = idx_ok;
      end
   end

endmodule

@@ hdl/clut_texel_decoder.sv @@
// Palette-indexed texel decoder, RGBA8 out.
//
// req_chan carries one word per item: func 0 loads a palette entry
// (entry_position, entry_word, converted by palette_format), func 1 decodes
// one pixel (pixel_word, pixel_odd, by image_format). Only pixel words give
// a response word on rsp_chan; loads give none.
// Throughput is one word per cycle, loads and pixels alike, while rsp_chan
// does not stall. A pixel's response passes the registered read port of
// the palette RAM (stage 1), then the output register. A load written at
// one edge is seen by a pixel accepted at the next. The user is to write
// registers (psel/penable/pwrite/paddr) only while the block is idle; the
// block does not enforce it. Reset clears the registers and both pipeline
// stages; the palette RAM is not cleared and holds garbage until loaded.
// When rsp_chan stalls, the response and one pixel behind it are held and
// req_chan.ready drops once both stages are full.
`include "clut_texel_decoder_macros.svh"

module clut_texel_decoder (
   input  logic         clock,
   input  logic         reset,
   ctd_req_if.sink      req_chan,
   ctd_rsp_if.source    rsp_chan,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [4:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   ctd_pkg::cfg_type               cfg;
   ctd_pkg::ram_wr_type            dec_wr;
   ctd_pkg::pix_info_type          dec_info;
   logic [ctd_pkg::ADDR_W-1:0]     dec_raddr;
   logic [ctd_pkg::WORD_W-1:0]     ram_rdata;
   logic                           accept;
   logic                           s1_go;
   logic                           ram_we;
   logic                           ram_re;
   logic [ctd_pkg::WORD_W-1:0]     s1_rgba;

   logic                           s1_v_ff, s1_v_in;
   ctd_pkg::pix_info_type          s1_info_ff;
   logic                           out_v_ff, out_v_in;
   logic [ctd_pkg::WORD_W-1:0]     out_rgba_ff;

   ctd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ctd_decode u_decode (
      .cfg            (cfg),
      .entry_position (req_chan.entry_position),
      .entry_word     (req_chan.entry_word),
      .pixel_word     (req_chan.pixel_word),
      .pixel_odd      (req_chan.pixel_odd),
      .wr             (dec_wr),
      .raddr          (dec_raddr),
      .info           (dec_info)
   );

   // handshake
   assign s1_go          = !out_v_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_v_ff || s1_go;
   assign accept         = req_chan.valid && req_chan.ready;

   assign ram_we = accept && !req_chan.func && dec_wr.we;
   assign ram_re = accept && req_chan.func && dec_info.use_mem;

   ctd_ram #(
      .DEPTH (ctd_pkg::PALETTE_DEPTH),
      .WIDTH (ctd_pkg::WORD_W)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (dec_wr.addr),
      .wdata (dec_wr.data),
      .re    (ram_re),
      .raddr (dec_raddr),
      .rdata (ram_rdata)
   );

   // stage 1: pixel info alongside the RAM read
   always_comb begin
      if (accept) begin
         s1_v_in = req_chan.func;
      end else if (s1_go) begin
         s1_v_in = 1'b0;
      end else begin
         s1_v_in = s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_chan.func) begin
         s1_info_ff <= dec_info;
      end
   end

   assign s1_rgba = s1_info_ff.use_mem ? ram_rdata : s1_info_ff.direct;

   // output register
   assign out_v_in = s1_go ? s1_v_ff : out_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_v_ff) begin
         out_rgba_ff <= s1_rgba;
      end
   end

   assign rsp_chan.valid = out_v_ff;
   assign rsp_chan.red   = out_rgba_ff[7:0];
   assign rsp_chan.green = out_rgba_ff[15:8];
   assign rsp_chan.blue  = out_rgba_ff[23:16];
   assign rsp_chan.alpha = out_rgba_ff[31:24];

   // checks
   `CTD_ASSERT_NEXT(a_s1_holds, clock, reset, s1_v_ff && !s1_go, s1_v_ff)
   `CTD_ASSERT_NEXT(a_pixel_enters, clock, reset, accept && req_chan.func, s1_v_ff)
   `CTD_ASSERT_NEXT(a_load_no_word, clock, reset,
                    accept && !req_chan.func && !s1_v_ff, !s1_v_ff)
   `CTD_ASSERT_ALWAYS(a_ram_one_port, clock, reset, !(ram_we && ram_re))
   `CTD_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !s1_v_ff && !out_v_ff)

endmodule
